// ----- rtl/core/vatf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vatf_pkg
// Shared types, format codes and helpers for the vertex attribute converter.
// ----------------------------------------------------------------------------
package vatf_pkg;

    localparam int unsigned LANES = 4;

    localparam logic [2:0] FMT_RGBA16 = 3'd0;
    localparam logic [2:0] FMT_RGB32F = 3'd1;
    localparam logic [2:0] FMT_RGBA8  = 3'd2;
    localparam logic [2:0] FMT_RG32F  = 3'd3;
    localparam logic [2:0] FMT_R8     = 3'd4;

    localparam logic [1:0] NT_SNORM = 2'd0;
    localparam logic [1:0] NT_UNORM = 2'd1;
    localparam logic [1:0] NT_SINT  = 2'd2;
    localparam logic [1:0] NT_UINT  = 2'd3;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_NTYPE  = 2'd1;

    // Per-lane conversion controls
    typedef struct packed {
        logic w16;   // 16-bit components, else 8-bit
        logic norm;  // snorm or unorm
        logic sgn;   // signed interpretation
        logic flt;   // float pass-through
    } t_lane_cfg;

    function automatic t_lane_cfg vatf_decode(input logic [2:0] fmt, input logic [1:0] nt);
        t_lane_cfg c;
        c.w16  = (fmt == FMT_RGBA16);
        c.flt  = (fmt == FMT_RGB32F) || (fmt == FMT_RG32F);
        c.norm = (nt == NT_SNORM) || (nt == NT_UNORM);
        c.sgn  = (nt == NT_SNORM) || (nt == NT_SINT);
        return c;
    endfunction

    function automatic logic [2:0] vatf_count(input logic [2:0] fmt);
        logic [2:0] n;
        unique case (fmt)
            FMT_RGBA16: n = 3'd4;
            FMT_RGB32F: n = 3'd3;
            FMT_RGBA8:  n = 3'd4;
            FMT_RG32F:  n = 3'd2;
            FMT_R8:     n = 3'd1;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

    // x / (2^len - 1) for x < 2^len - 1 is x repeated as a binary fraction
    function automatic logic [47:0] vatf_rep(input logic [15:0] p, input int len);
        logic [47:0] f;
        int k;
        f = '0;
        k = 0;
        for (int j = 0; j < 48; j++) begin
            f[47 - j] = p[len - 1 - k];
            k = k + 1;
            if (k == len) begin
                k = 0;
            end
        end
        return f;
    endfunction

endpackage

// ----- rtl/core/vatf_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vatf_in_if
// Vertex item channel: four raw components and the last marker.
// ----------------------------------------------------------------------------
interface vatf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] component_0;
    logic [31:0] component_1;
    logic [31:0] component_2;
    logic [31:0] component_3;
    logic        last_vertex;

    modport source (output valid, component_0, component_1, component_2, component_3,
                    last_vertex, input ready);
    modport sink (input valid, component_0, component_1, component_2, component_3,
                  last_vertex, output ready);
endinterface

// ----- rtl/core/vatf_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vatf_out_if
// Result item channel: four single-precision values, lane count, last marker.
// ----------------------------------------------------------------------------
interface vatf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_0;
    logic [31:0] value_1;
    logic [31:0] value_2;
    logic [31:0] value_3;
    logic [2:0]  component_count;
    logic        last_out;

    modport source (output valid, value_0, value_1, value_2, value_3, component_count,
                    last_out, input ready);
    modport sink (input valid, value_0, value_1, value_2, value_3, component_count,
                  last_out, output ready);
endinterface

// ----- rtl/core/vatf_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vatf_lane
// One conversion lane: builds a fixed-point value (a quotient for snorm/unorm),
// registers it, then normalises and rounds to single precision; float input passes through.
// ----------------------------------------------------------------------------
module vatf_lane
    import vatf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_raw,
    input  t_lane_cfg   i_cfg,
    output logic [31:0] o_value
);

    logic [15:0] u;
    logic        neg;
    logic [16:0] mag;
    logic [16:0] div;
    logic        ipart;
    logic [15:0] pat;
    logic [47:0] frac;
    logic [64:0] y;
    logic [5:0]  lz;

    logic [64:0] r_y;
    logic [5:0]  r_lz;
    logic        r_sign;
    logic        r_sticky;
    logic        r_zero;
    logic        r_flt;
    logic [31:0] r_raw;

    always_comb begin
        u   = i_cfg.w16 ? i_raw[15:0] : {8'd0, i_raw[7:0]};
        neg = i_cfg.sgn && (i_cfg.w16 ? i_raw[15] : i_raw[7]);
        if (neg) begin
            mag = i_cfg.w16 ? (17'h10000 - {1'b0, u}) : (17'h00100 - {1'b0, u});
        end else begin
            mag = {1'b0, u};
        end
        priority if (i_cfg.w16 && i_cfg.sgn) begin
            div = 17'd32767;
        end else if (i_cfg.w16) begin
            div = 17'd65535;
        end else if (i_cfg.sgn) begin
            div = 17'd127;
        end else begin
            div = 17'd255;
        end
        ipart = (mag >= div);
        pat   = ipart ? 16'(mag - div) : mag[15:0];
        priority if (i_cfg.w16 && i_cfg.sgn) begin
            frac = vatf_rep(pat, 15);
        end else if (i_cfg.w16) begin
            frac = vatf_rep(pat, 16);
        end else if (i_cfg.sgn) begin
            frac = vatf_rep(pat, 7);
        end else begin
            frac = vatf_rep(pat, 8);
        end
        y = i_cfg.norm ? {16'd0, ipart, frac} : {mag, 48'd0};
        // leading one always sits in the top 33 bits
        lz = 6'd32;
        for (int i = 0; i < 33; i++) begin
            if (y[32 + i]) begin
                lz = 6'(32 - i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y      <= y;
            r_lz     <= lz;
            r_sign   <= neg;
            r_sticky <= i_cfg.norm && (pat != 16'd0);
            r_zero   <= (mag == 17'd0);
            r_flt    <= i_cfg.flt;
            r_raw    <= i_raw;
        end
    end

    logic [64:0] z;
    logic [22:0] mant;
    logic        g;
    logic        st;
    logic [23:0] mant_r;
    logic [7:0]  expo;

    always_comb begin
        z      = r_y << r_lz;
        mant   = z[63:41];
        g      = z[40];
        st     = (|z[39:0]) || r_sticky;
        mant_r = {1'b0, mant} + 24'(g && (st || mant[0]));
        expo   = 8'd143 - {2'd0, r_lz} + {7'd0, mant_r[23]};
        priority if (r_flt) begin
            o_value = r_raw;
        end else if (r_zero) begin
            o_value = 32'd0;
        end else begin
            o_value = {r_sign, expo, mant_r[22:0]};
        end
    end

endmodule

// ----- rtl/core/vatf_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vatf_merge
// Output register: gathers the lane values, clears unused lanes, adds count.
// ----------------------------------------------------------------------------
module vatf_merge
    import vatf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [2:0]  i_fmt,
    input  logic        i_last,
    input  logic [31:0] i_value [LANES],
    output logic [31:0] o_value [LANES],
    output logic [2:0]  o_count,
    output logic        o_last
);

    logic [2:0]  cnt;
    logic [31:0] r_value [LANES];
    logic [2:0]  r_count;
    logic        r_last;

    assign cnt = vatf_count(i_fmt);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < LANES; i++) begin
                r_value[i] <= (3'(i) < cnt) ? i_value[i] : 32'd0;
            end
            r_count <= cnt;
            r_last  <= i_last;
        end
    end

    assign o_value = r_value;
    assign o_count = r_count;
    assign o_last  = r_last;

endmodule

// ----- rtl/core/vertex_attribute_to_float_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_attribute_to_float_core
// Converts one vertex of up to four snorm/unorm/sint/uint or float components
// to IEEE single-precision values.
// ----------------------------------------------------------------------------
// Takes one vertex per cycle unless the output stalls. Four lanes each
// register a fixed-point quotient (divisions by 2^n-1 become a repeated
// bit pattern), then normalise and round into the output register.
// Snorm/unorm results are correctly rounded singles. Write the format and
// number-type registers only while no item is in flight.
module vertex_attribute_to_float_core
    import vatf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [2:0] i_cfg_data,
    vatf_in_if.sink    i_vtx,
    vatf_out_if.source o_res
);

    logic [2:0] r_fmt;
    logic [1:0] r_ntype;
    logic       r_v1;
    logic       r_v2;
    logic       r_last1;
    logic       en1;
    logic       en2;
    t_lane_cfg  lcfg;

    logic [31:0] raw      [LANES];
    logic [31:0] lane_val [LANES];
    logic [31:0] out_val  [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= FMT_RGBA16;
            r_ntype <= NT_SNORM;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_FORMAT) begin
                r_fmt <= i_cfg_data;
            end else if (i_cfg_idx == REG_NTYPE) begin
                r_ntype <= i_cfg_data[1:0];
            end
        end
    end

    assign en2         = !r_v2 || o_res.ready;
    assign en1         = !r_v1 || en2;
    assign i_vtx.ready = en1;
    assign lcfg        = vatf_decode(r_fmt, r_ntype);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_vtx.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_last1 <= i_vtx.last_vertex;
        end
    end

    assign raw[0] = i_vtx.component_0;
    assign raw[1] = i_vtx.component_1;
    assign raw[2] = i_vtx.component_2;
    assign raw[3] = i_vtx.component_3;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        vatf_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en1),
            .i_raw   (raw[g]),
            .i_cfg   (lcfg),
            .o_value (lane_val[g])
        );
    end

    vatf_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (en2),
        .i_fmt   (r_fmt),
        .i_last  (r_last1),
        .i_value (lane_val),
        .o_value (out_val),
        .o_count (o_res.component_count),
        .o_last  (o_res.last_out)
    );

    assign o_res.valid   = r_v2;
    assign o_res.value_0 = out_val[0];
    assign o_res.value_1 = out_val[1];
    assign o_res.value_2 = out_val[2];
    assign o_res.value_3 = out_val[3];

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_vtx.ready |-> (r_v1 && r_v2))
        else $error("input stalled with a free stage");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.component_count < 3'd4) |-> (o_res.value_3 == 32'd0))
        else $error("unused lane not cleared");

    a_bad_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.component_count == 3'd0) |->
        (o_res.value_0 == 32'd0 && o_res.value_1 == 32'd0))
        else $error("bad format gave values");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && en2) |=> r_v2)
        else $error("item lost between stages");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for vertex_attribute_to_float_core. Vertices are sent
// under random gaps and output stalls. Each accepted vertex is converted by a
// local model of the lane arithmetic and queued. Each returned result is
// compared field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module tb_top;
    import vatf_pkg::*;

    typedef struct packed {
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] v2;
        logic [31:0] v3;
        logic [2:0]  cnt;
        logic        last;
    } t_conv;

    localparam int unsigned LIMIT = 400000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [2:0] i_cfg_data;

    vatf_in_if  vin ();
    vatf_out_if vout ();

    vertex_attribute_to_float_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_vtx      (vin.sink),
        .o_res      (vout.source)
    );

    logic [2:0] cur_fmt;
    logic [1:0] cur_nt;
    t_conv      pending_conv[$];
    int         n_errors = 0;
    int         cycles = 0;
    bit         no_idle;
    int         stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 70) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(30, 5);
    endfunction

    // Round a double to the nearest single; all values here are normal or zero
    function automatic logic [31:0] to_single(input real r);
        logic [63:0] b;
        logic [10:0] e;
        logic [30:0] em;
        b = $realtobits(r);
        if (b[62:0] == '0) return {b[63], 31'b0};
        e  = b[62:52] - 11'd896;
        em = {e[7:0], b[51:29]};
        if (b[28] && ((|b[27:0]) || b[29])) em = em + 31'd1;
        return {b[63], em};
    endfunction

    function automatic logic [31:0] lane_to_float(input logic [31:0] raw, input bit w16,
                                                  input logic [1:0] nt);
        int u;
        int s;
        real r;
        u = w16 ? int'(raw[15:0]) : int'(raw[7:0]);
        s = w16 ? int'($signed(raw[15:0])) : int'($signed(raw[7:0]));
        case (nt)
            NT_SNORM: r = real'(s) / (w16 ? 32767.0 : 127.0);
            NT_UNORM: r = real'(u) / (w16 ? 65535.0 : 255.0);
            NT_SINT:  r = real'(s);
            default:  r = real'(u);
        endcase
        return to_single(r);
    endfunction

    function automatic t_conv convert_vertex(input logic [31:0] c0, input logic [31:0] c1,
                                             input logic [31:0] c2, input logic [31:0] c3,
                                             input logic last);
        t_conv e;
        e = '0;
        e.last = last;
        case (cur_fmt)
            FMT_RGBA16, FMT_RGBA8: begin
                e.cnt = 3'd4;
                e.v0 = lane_to_float(c0, cur_fmt == FMT_RGBA16, cur_nt);
                e.v1 = lane_to_float(c1, cur_fmt == FMT_RGBA16, cur_nt);
                e.v2 = lane_to_float(c2, cur_fmt == FMT_RGBA16, cur_nt);
                e.v3 = lane_to_float(c3, cur_fmt == FMT_RGBA16, cur_nt);
            end
            FMT_RGB32F: begin
                e.cnt = 3'd3;
                e.v0 = c0;
                e.v1 = c1;
                e.v2 = c2;
            end
            FMT_RG32F: begin
                e.cnt = 3'd2;
                e.v0 = c0;
                e.v1 = c1;
            end
            FMT_R8: begin
                e.cnt = 3'd1;
                e.v0 = lane_to_float(c0, 1'b0, cur_nt);
            end
            default: e.cnt = 3'd0;
        endcase
        return e;
    endfunction

    // Input monitor: predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && vin.valid && vin.ready) begin
            pending_conv.insert(pending_conv.size(),
                                convert_vertex(vin.component_0, vin.component_1,
                                               vin.component_2, vin.component_3,
                                               vin.last_vertex));
        end
    end

    // Output checker
    always @(posedge i_clk) begin
        t_conv e;
        if (i_rst_n && vout.valid && vout.ready) begin
            if (pending_conv.size() == 0) begin
                $error("unexpected result item");
                n_errors++;
            end else begin
                e = pending_conv.pop_front();
                if (vout.value_0 !== e.v0) begin
                    $error("value_0 exp %h got %h", e.v0, vout.value_0);
                    n_errors++;
                end
                if (vout.value_1 !== e.v1) begin
                    $error("value_1 exp %h got %h", e.v1, vout.value_1);
                    n_errors++;
                end
                if (vout.value_2 !== e.v2) begin
                    $error("value_2 exp %h got %h", e.v2, vout.value_2);
                    n_errors++;
                end
                if (vout.value_3 !== e.v3) begin
                    $error("value_3 exp %h got %h", e.v3, vout.value_3);
                    n_errors++;
                end
                if (vout.component_count !== e.cnt) begin
                    $error("component_count exp %0d got %0d", e.cnt, vout.component_count);
                    n_errors++;
                end
                if (vout.last_out !== e.last) begin
                    $error("last_out exp %0d got %0d", e.last, vout.last_out);
                    n_errors++;
                end
            end
        end
    end

    // Output back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            vout.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            vout.ready <= 1'b1;
            if (!no_idle && $urandom_range(9) < 2) stall_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic send_vertex(input logic [31:0] c0, input logic [31:0] c1,
                               input logic [31:0] c2, input logic [31:0] c3,
                               input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            vin.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        vin.valid       <= 1'b1;
        vin.component_0 <= c0;
        vin.component_1 <= c1;
        vin.component_2 <= c2;
        vin.component_3 <= c3;
        vin.last_vertex <= last;
        @(posedge i_clk);
        while (!vin.ready) @(posedge i_clk);
    endtask

    // Drain the pipeline, then write one register
    task automatic write_reg(input logic [1:0] idx, input logic [2:0] data);
        vin.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_conv.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_FORMAT) cur_fmt = data;
        else if (idx == REG_NTYPE) cur_nt = data[1:0];
    endtask

    function automatic logic [31:0] rand_comp();
        logic [31:0] c;
        c = $urandom();
        case ($urandom_range(7))
            0: c[15:0] = 16'h8000;
            1: c[15:0] = 16'h7FFF;
            2: c[7:0]  = 8'h80;
            3: c[7:0]  = 8'h7F;
            default: ;
        endcase
        return c;
    endfunction

    task automatic test_int_extremes();
        for (int nt = 0; nt < 4; nt++) begin
            write_reg(REG_NTYPE, 3'(nt));
            write_reg(REG_FORMAT, FMT_RGBA8);
            send_vertex(32'h80, 32'h7F, 32'hFFFF_FFFF, 32'h0, 1'b0);
            write_reg(REG_FORMAT, FMT_RGBA16);
            send_vertex(32'h8000, 32'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_0000, 1'b1);
            write_reg(REG_FORMAT, FMT_R8);
            send_vertex(32'hFFFF_FF81, 32'h1, 32'h2, 32'h3, 1'b0);
        end
    endtask

    task automatic test_float_and_bad_codes();
        write_reg(REG_FORMAT, FMT_RGB32F);
        send_vertex(32'h7FC0_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1);
        write_reg(REG_FORMAT, FMT_RG32F);
        send_vertex(32'h0000_0001, 32'h7F80_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        // unused format codes give count zero
        for (int f = 5; f < 8; f++) begin
            write_reg(REG_FORMAT, 3'(f));
            send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        end
        // writes beyond the last register are dropped
        write_reg(REG_FORMAT, FMT_RGBA8);
        write_reg(2'd2, 3'd7);
        write_reg(2'd3, 3'd4);
        send_vertex(32'h81, 32'hFE, 32'h40, 32'hC0, 1'b0);
    endtask

    task automatic test_random_stream();
        logic [2:0] f;
        for (int ph = 0; ph < 35; ph++) begin
            f = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
            if ($urandom_range(7) == 0) write_reg(2'($urandom_range(3, 2)), 3'($urandom()));
            write_reg(REG_FORMAT, f);
            write_reg(REG_NTYPE, 3'($urandom_range(7)));
            no_idle = ($urandom_range(4) == 0);
            for (int n = 0; n < 50; n++) begin
                send_vertex(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                            1'($urandom_range(1)));
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        vin.valid       = 1'b0;
        vin.component_0 = '0;
        vin.component_1 = '0;
        vin.component_2 = '0;
        vin.component_3 = '0;
        vin.last_vertex = 1'b0;
        cur_fmt         = FMT_RGBA16;
        cur_nt          = NT_SNORM;
        no_idle         = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // reset values first, before any write
        send_vertex(32'h8000, 32'h7FFF, 32'h0, 32'hFFFF, 1'b1);
        test_int_extremes();
        test_float_and_bad_codes();
        test_random_stream();
        vin.valid <= 1'b0;
        while (pending_conv.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
